// File: src/dda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line pixel generator package
// Shared constants, register indexes, action codes and small types.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 20;

  localparam int CANVAS_BITS  = 13;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CANVAS_BITS-1:0] CANVAS_W_RST = 13'd640;
  localparam logic [CANVAS_BITS-1:0] CANVAS_H_RST = 13'd480;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_HEIGHT = 1'd1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Control from the sequencer to the pixel datapath.
  typedef struct packed {
    logic abandon;  // a new line was started, drop the current one
    logic load;     // slope is ready, load the line state
    logic step;     // a step word was accepted
  } pix_ctrl_t;

endpackage

// File: src/dda_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line pixel generator channel interfaces
// Command, pixel and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface dda_in_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic [7:0]                   red_in;
  logic [7:0]                   green_in;
  logic [7:0]                   blue_in;

  modport source (output valid, action, first_x, first_y, second_x, second_y,
                  red_in, green_in, blue_in, input ready);
  modport sink (input valid, action, first_x, first_y, second_x, second_y,
                red_in, green_in, blue_in, output ready);
endinterface

interface dda_out_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [7:0]                   red_out;
  logic [7:0]                   green_out;
  logic [7:0]                   blue_out;
  logic                         drawn;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, red_out, green_out, blue_out,
                  drawn, last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, red_out, green_out, blue_out,
                drawn, last_pixel, output ready);
endinterface

interface dda_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dda_pkg::CFG_IDX_BITS-1:0] index;
  logic [dda_pkg::CANVAS_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/dda_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA slope divider
// Restoring divider, one quotient bit per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
module dda_div #(
  parameter int NUM_W = 17,
  parameter int Q_W   = 21
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] numer,
  input  logic [NUM_W-1:0]        denom,
  output logic                    done,
  output logic signed [Q_W:0]     quot
);
  localparam int CNT_W = $clog2(Q_W);

  logic [NUM_W:0]   rem_r;
  logic [Q_W-1:0]   q_r;
  logic [NUM_W-1:0] den_r;
  logic             neg_r;
  logic             zero_r;
  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;

  logic [NUM_W-1:0] numer_mag;
  logic [NUM_W+1:0] trial;
  logic             fits;
  logic [NUM_W-1:0] rem_sel;
  logic [Q_W:0]     q_ext;

  // The numerator magnitude never exceeds the denominator, so the quotient
  // has only Q_W bits and the first partial remainder is the numerator itself.
  assign numer_mag = numer[NUM_W-1] ? (-numer) : numer;
  assign trial     = {1'b0, rem_r} - {2'b00, den_r};
  assign fits      = ~trial[NUM_W+1];
  assign rem_sel   = fits ? trial[NUM_W-1:0] : rem_r[NUM_W-1:0];
  assign q_ext     = {1'b0, q_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, numer_mag};
      q_r    <= '0;
      den_r  <= denom;
      neg_r  <= numer[NUM_W-1];
      zero_r <= (denom == '0);
    end else if (busy_r) begin
      rem_r <= {rem_sel, 1'b0};
      q_r   <= {q_r[Q_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = zero_r ? '0 : (neg_r ? (-q_ext) : q_ext);

endmodule

// File: src/dda_pix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA pixel stepper
// Holds the line state, produces one clipped pixel per step into a result
// register and advances the major coordinate and the minor accumulator.
// ----------------------------------------------------------------------------
module dda_pix #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dda_pkg::pix_ctrl_t                ctrl,
  input  logic                              ld_steep,
  input  logic signed [COORD_BITS-1:0]      ld_major_start,
  input  logic signed [COORD_BITS-1:0]      ld_major_end,
  input  logic signed [COORD_BITS-1:0]      ld_minor_start,
  input  logic signed [FRAC_BITS+1:0]       ld_slope,
  input  dda_pkg::rgb_t                     ld_color,
  input  logic [dda_pkg::CANVAS_BITS-1:0]   canvas_w,
  input  logic [dda_pkg::CANVAS_BITS-1:0]   canvas_h,
  input  logic                              res_ready,
  output logic                              res_valid,
  output logic signed [COORD_BITS-1:0]      res_x,
  output logic signed [COORD_BITS-1:0]      res_y,
  output dda_pkg::rgb_t                     res_color,
  output logic                              res_drawn,
  output logic                              res_last
);
  import dda_pkg::*;

  localparam int CW    = COORD_BITS + 1;
  localparam int SW    = FRAC_BITS + 2;
  localparam int AW    = COORD_BITS + FRAC_BITS + 1;
  localparam int CMP_W = (COORD_BITS > CANVAS_BITS) ? COORD_BITS : CANVAS_BITS;

  logic                 busy_r;
  logic                 steep_r;
  logic signed [CW-1:0] major_now_r;
  logic signed [CW-1:0] major_end_r;
  logic signed [AW-1:0] accum_r;
  logic signed [SW-1:0] slope_r;
  rgb_t                 color_r;

  logic                 res_valid_r;
  logic [COORD_BITS-1:0] res_x_r;
  logic [COORD_BITS-1:0] res_y_r;
  rgb_t                 res_color_r;
  logic                 res_drawn_r;
  logic                 res_last_r;

  logic signed [CW-1:0] minor;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic                 on_canvas;
  logic                 last;
  logic                 emit;

  // Truncation toward zero: a negative accumulator with a fraction rounds up.
  assign minor = accum_r[AW-1:FRAC_BITS]
               + CW'(accum_r[AW-1] && (accum_r[FRAC_BITS-1:0] != '0));
  assign px    = steep_r ? minor : major_now_r;
  assign py    = steep_r ? major_now_r : minor;

  assign on_canvas = !px[CW-1] && !py[CW-1]
                  && (CMP_W'(px[COORD_BITS-1:0]) < CMP_W'(canvas_w))
                  && (CMP_W'(py[COORD_BITS-1:0]) < CMP_W'(canvas_h));
  assign last   = (major_now_r >= major_end_r);
  assign emit   = ctrl.step && busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (ctrl.load) begin
        busy_r <= 1'b1;
      end else if (ctrl.abandon || (emit && last)) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      steep_r     <= ld_steep;
      major_now_r <= {ld_major_start[COORD_BITS-1], ld_major_start};
      major_end_r <= {ld_major_end[COORD_BITS-1], ld_major_end};
      accum_r     <= {ld_minor_start[COORD_BITS-1], ld_minor_start, {FRAC_BITS{1'b0}}};
      slope_r     <= ld_slope;
      color_r     <= ld_color;
    end else if (emit && !last) begin
      major_now_r <= major_now_r + CW'(1);
      accum_r     <= accum_r + {{(AW-SW){slope_r[SW-1]}}, slope_r};
    end
    if (emit) begin
      res_x_r     <= px[COORD_BITS-1:0];
      res_y_r     <= py[COORD_BITS-1:0];
      res_color_r <= color_r;
      res_drawn_r <= on_canvas;
      res_last_r  <= last;
    end
  end

  assign res_valid = res_valid_r;
  assign res_x     = res_x_r;
  assign res_y     = res_y_r;
  assign res_color = res_color_r;
  assign res_drawn = res_drawn_r;
  assign res_last  = res_last_r;

endmodule

// File: src/dda_line_pixel_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line pixel generator unit
// Rasterizes a line from two endpoints: a start word sets up the line and
// computes a fixed-point slope, each step word returns the next pixel.
// ----------------------------------------------------------------------------
// Start word: the command channel stays busy through line setup, while the
//   restoring divider produces the slope at one slope bit per cycle.
// Step word: one pixel word per cycle while the result side keeps up; the
//   result register is refilled in the same cycle it is taken.
// Reset (rst_n low, synchronous): no line active, result register empty,
//   canvas 640 x 480.
// ----------------------------------------------------------------------------
module dda_line_pixel_generator_unit #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  dda_in_if.sink     in_ch,
  dda_out_if.source  out_ch,
  dda_cfg_if.sink    cfg_ch
);
  import dda_pkg::*;

  localparam int CW = COORD_BITS + 1;
  localparam int QW = FRAC_BITS + 1;

  // Setup sequencer. ORIENT picks the major axis, ORDER sorts the endpoints
  // along it and forms the deltas, LAUNCH starts the divider and DIV waits
  // for the slope before the line is handed to the stepper.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ORIENT = 5'b00010,
    ST_ORDER  = 5'b00100,
    ST_LAUNCH = 5'b01000,
    ST_DIV    = 5'b10000
  } state_t;

  state_t st_r;
  state_t st_nxt;

  // Configuration registers.
  logic [CANVAS_BITS-1:0] canvas_w_r;
  logic [CANVAS_BITS-1:0] canvas_h_r;

  // Endpoints and color captured from the start word.
  logic signed [COORD_BITS-1:0] ax_r;
  logic signed [COORD_BITS-1:0] ay_r;
  logic signed [COORD_BITS-1:0] bx_r;
  logic signed [COORD_BITS-1:0] by_r;
  rgb_t                         color_r;

  // Endpoints remapped to major/minor axes.
  logic                         steep_r;
  logic signed [COORD_BITS-1:0] amaj_r;
  logic signed [COORD_BITS-1:0] amin_r;
  logic signed [COORD_BITS-1:0] bmaj_r;
  logic signed [COORD_BITS-1:0] bmin_r;

  // Ordered endpoints and deltas feeding the divider.
  logic signed [COORD_BITS-1:0] smaj_r;
  logic signed [COORD_BITS-1:0] emaj_r;
  logic signed [COORD_BITS-1:0] smin_r;
  logic signed [CW-1:0]         dmaj_r;
  logic signed [CW-1:0]         dmin_r;

  logic                 in_acc;
  logic                 start_acc;
  logic                 step_acc;
  logic                 in_ready;
  logic                 res_valid;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] adx;
  logic signed [CW-1:0] ady;
  logic                 steep;
  logic                 swap;
  logic signed [COORD_BITS-1:0] smaj;
  logic signed [COORD_BITS-1:0] emaj;
  logic signed [COORD_BITS-1:0] smin;
  logic signed [COORD_BITS-1:0] emin;

  logic                 div_done;
  logic signed [QW:0]   div_quot;
  pix_ctrl_t            pix_ctrl;
  rgb_t                 res_color;

  // ---------------------------------------------------------------------------
  // Handshakes. Words are taken only when the sequencer is idle and the result
  // register is free or being emptied in this cycle, so a step never has to
  // wait on a pending pixel inside the block.
  // ---------------------------------------------------------------------------
  assign in_ready    = (st_r == ST_IDLE) && (!res_valid || out_ch.ready);
  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;
  assign start_acc   = in_acc && (in_ch.action == ACT_START);
  assign step_acc    = in_acc && (in_ch.action == ACT_STEP);

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_w_r <= CANVAS_W_RST;
      canvas_h_r <= CANVAS_H_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_CANVAS_WIDTH:  canvas_w_r <= cfg_ch.data;
        REG_CANVAS_HEIGHT: canvas_h_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (start_acc) st_nxt = ST_ORIENT;
      ST_ORIENT: st_nxt = ST_ORDER;
      ST_ORDER:  st_nxt = ST_LAUNCH;
      ST_LAUNCH: st_nxt = ST_DIV;
      ST_DIV:    if (div_done) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Orientation: y is the major axis unless |dy| < |dx|, which also covers
  // the equal-endpoint case.
  // ---------------------------------------------------------------------------
  assign dx    = {bx_r[COORD_BITS-1], bx_r} - {ax_r[COORD_BITS-1], ax_r};
  assign dy    = {by_r[COORD_BITS-1], by_r} - {ay_r[COORD_BITS-1], ay_r};
  assign adx   = dx[CW-1] ? (-dx) : dx;
  assign ady   = dy[CW-1] ? (-dy) : dy;
  assign steep = !(ady < adx);

  // Ordering: the major coordinate ascends from the start endpoint.
  assign swap = (amaj_r > bmaj_r);
  assign smaj = swap ? bmaj_r : amaj_r;
  assign emaj = swap ? amaj_r : bmaj_r;
  assign smin = swap ? bmin_r : amin_r;
  assign emin = swap ? amin_r : bmin_r;

  always_ff @(posedge clk) begin
    if (start_acc) begin
      ax_r          <= in_ch.first_x;
      ay_r          <= in_ch.first_y;
      bx_r          <= in_ch.second_x;
      by_r          <= in_ch.second_y;
      color_r.red   <= in_ch.red_in;
      color_r.green <= in_ch.green_in;
      color_r.blue  <= in_ch.blue_in;
    end
    if (st_r == ST_ORIENT) begin
      steep_r <= steep;
      amaj_r  <= steep ? ay_r : ax_r;
      amin_r  <= steep ? ax_r : ay_r;
      bmaj_r  <= steep ? by_r : bx_r;
      bmin_r  <= steep ? bx_r : by_r;
    end
    if (st_r == ST_ORDER) begin
      smaj_r <= smaj;
      emaj_r <= emaj;
      smin_r <= smin;
      dmaj_r <= {emaj[COORD_BITS-1], emaj} - {smaj[COORD_BITS-1], smaj};
      dmin_r <= {emin[COORD_BITS-1], emin} - {smin[COORD_BITS-1], smin};
    end
  end

  // ---------------------------------------------------------------------------
  // Slope divider: slope = (d_minor << FRAC_BITS) / d_major, toward zero.
  // The major delta is never negative after ordering.
  // ---------------------------------------------------------------------------
  dda_div #(
    .NUM_W (CW),
    .Q_W   (QW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == ST_LAUNCH),
    .numer (dmin_r),
    .denom (dmaj_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Pixel stepper and result register.
  // ---------------------------------------------------------------------------
  assign pix_ctrl.abandon = start_acc;
  assign pix_ctrl.load    = (st_r == ST_DIV) && div_done;
  assign pix_ctrl.step    = step_acc;

  dda_pix #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_pix (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (pix_ctrl),
    .ld_steep       (steep_r),
    .ld_major_start (smaj_r),
    .ld_major_end   (emaj_r),
    .ld_minor_start (smin_r),
    .ld_slope       (div_quot),
    .ld_color       (color_r),
    .canvas_w       (canvas_w_r),
    .canvas_h       (canvas_h_r),
    .res_ready      (out_ch.ready),
    .res_valid      (res_valid),
    .res_x          (out_ch.pixel_x),
    .res_y          (out_ch.pixel_y),
    .res_color      (res_color),
    .res_drawn      (out_ch.drawn),
    .res_last       (out_ch.last_pixel)
  );

  assign out_ch.valid     = res_valid;
  assign out_ch.red_out   = res_color.red;
  assign out_ch.green_out = res_color.green;
  assign out_ch.blue_out  = res_color.blue;

endmodule

// File: src/dda_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line pixel generator port checker
// Checks handshake and start-sequence behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module dda_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_action,
  input logic out_valid,
  input logic out_ready
);
  import dda_pkg::*;

  logic start_acc;
  assign start_acc = in_valid && in_ready && (in_action == ACT_START);

  // A pixel word stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel word dropped before it was taken");

  // Setting up a line blocks the command channel while the slope is computed.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start_acc |=> !in_ready)
    else $error("command accepted during line setup");

  // A start word produces no pixel and leaves the result register empty.
  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start_acc |=> !out_valid)
    else $error("pixel word appeared after a start word");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("pixel word offered right after reset");

endmodule

bind dda_line_pixel_generator_unit dda_chk u_dda_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
